// File: hw/rtl/nbbc_pkg.sv
// Shared types, constants and saturating arithmetic for the naive Bayes classifier.
// No dependencies; used by every module in hw/rtl.
package nbbc_pkg;

  localparam int FEATURES_DEF = 1024;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  localparam logic REG_PRIOR    = 1'b0;
  localparam logic REG_DECISION = 1'b1;

  localparam logic signed [15:0] PRIOR_RESET    = 16'sd0;
  localparam logic signed [15:0] DECISION_RESET = 16'sd10204;

  localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic use_w;
    logic last;
    logic label;
  } feat_t;

  typedef struct packed {
    logic              label;
    logic signed [31:0] sum;
  } rec_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/naive_bayes_binary_classifier.sv
// Top level of the two-class naive Bayes classifier: stream ports, APB registers, pipeline.
// Depends on nbbc_pkg, nbbc_weight_mem, nbbc_accum and nbbc_decide.
//
//   channel   dir   handshake           content
//   s_*       in    s_tvalid/s_tready   write or feature beat, tlast ends a record
//   m_*       out   m_tvalid/m_tready   verdict, outcome, score per record
//   apb       in    psel/penable        prior_log_odds @0x0, decision_log_odds @0x4
//
// One beat per cycle while s_tready is high; for the edge that takes a record's last beat,
// the table is read on that edge, then the sum is accumulated into s2, then prior add and compare set m_tvalid.
// After reset the table sweep clears every entry with s_tready low.
// A stalled m_tready holds the result; input stalls only when all stages are full.
module naive_bayes_binary_classifier #(
  parameter int FEATURES = nbbc_pkg::FEATURES_DEF,
  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // feature_index[9:0], weight_value[25:10], present[26],
                                // true_label[27], zero[31:28]
  input  logic        s_tuser,  // opcode[0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // verdict[0], outcome[2:1], score[34:3], zero[39:35]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [15:0] prior;
  logic signed [15:0] decision;
  logic               cfg_wr;

  logic [16:0]        idx_ext;
  logic               in_range;
  logic [AW-1:0]      addr;
  logic               accept;
  logic               wr_en;
  logic               rd_en;
  logic signed [15:0] rd_data;
  logic               cleared;

  nbbc_pkg::feat_t    feat;
  nbbc_pkg::rec_t     rec;
  logic               rec_valid;
  logic               s1_free;
  logic               s2_free;
  logic               out_verdict;
  logic               out_label;
  logic signed [31:0] out_score;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == nbbc_pkg::REG_DECISION) ? {{16{decision[15]}}, decision}
                                                      : {{16{prior[15]}}, prior};

  always_ff @(posedge clk) begin
    if (rst) begin
      prior    <= nbbc_pkg::PRIOR_RESET;
      decision <= nbbc_pkg::DECISION_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == nbbc_pkg::REG_PRIOR) begin
        prior <= pwdata[15:0];
      end else begin
        decision <= pwdata[15:0];
      end
    end
  end

  assign idx_ext  = {7'd0, s_tdata[9:0]};
  assign in_range = idx_ext < 17'(FEATURES);
  assign addr     = idx_ext[AW-1:0];
  assign s_tready = cleared && s1_free;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = accept && (s_tuser == nbbc_pkg::OP_WRITE) && in_range;
  assign rd_en    = accept && (s_tuser == nbbc_pkg::OP_FEATURE);

  assign feat.use_w = s_tdata[26] && in_range;
  assign feat.last  = s_tlast;
  assign feat.label = s_tdata[27];

  nbbc_weight_mem #(
    .FEATURES(FEATURES)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (s_tdata[25:10]),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data),
    .cleared (cleared)
  );

  nbbc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .load      (rd_en),
    .feat      (feat),
    .rd_data   (rd_data),
    .s2_free   (s2_free),
    .s1_free   (s1_free),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  nbbc_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .prior       (prior),
    .decision    (decision),
    .m_tready    (m_tready),
    .s2_free     (s2_free),
    .out_valid   (m_tvalid),
    .out_verdict (out_verdict),
    .out_label   (out_label),
    .out_score   (out_score)
  );

  assign m_tdata = {5'd0, out_score, out_label, out_verdict, out_verdict};

endmodule

// File: hw/rtl/nbbc_weight_mem.sv
// Weight table: single-port-write, registered-read memory with a clearing sweep after reset.
// Depends on nbbc_pkg.
module nbbc_weight_mem #(
  parameter int FEATURES = nbbc_pkg::FEATURES_DEF,
  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [15:0]   wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [15:0]   rd_data,
  output logic                 cleared
);

  logic signed [15:0] mem [FEATURES];
  logic [AW-1:0]      clr_addr;
  logic               clearing;

  assign cleared = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(FEATURES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/nbbc_accum.sv
// Accumulate stage: adds the weight read from the table into the saturating running sum.
// Depends on nbbc_pkg; fed by nbbc_weight_mem read data.
module nbbc_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  nbbc_pkg::feat_t      feat,
  input  logic signed [15:0]   rd_data,
  input  logic                 s2_free,
  output logic                 s1_free,
  output logic                 rec_valid,
  output nbbc_pkg::rec_t       rec
);

  logic               s1_valid;
  nbbc_pkg::feat_t    s1;
  logic signed [31:0] running_sum;
  logic signed [31:0] addend;
  logic signed [31:0] sum_next;
  logic               s1_go;

  assign s1_go     = s1_valid && (!s1.last || s2_free);
  assign s1_free   = !s1_valid || s1_go;
  assign addend    = s1.use_w ? {{16{rd_data[15]}}, rd_data} : '0;
  assign sum_next  = nbbc_pkg::sat_add(running_sum, addend);
  assign rec_valid = s1_go && s1.last;
  assign rec.label = s1.label;
  assign rec.sum   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      running_sum <= '0;
    end else begin
      if (s1_go) begin
        running_sum <= s1.last ? '0 : sum_next;
      end
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= feat;
    end
  end

endmodule

// File: hw/rtl/nbbc_decide.sv
// Decision stage: adds the prior, compares with the threshold and holds the result beat.
// Depends on nbbc_pkg; fed by nbbc_accum.
module nbbc_decide (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  nbbc_pkg::rec_t       rec,
  input  logic signed [15:0]   prior,
  input  logic signed [15:0]   decision,
  input  logic                 m_tready,
  output logic                 s2_free,
  output logic                 out_valid,
  output logic                 out_verdict,
  output logic                 out_label,
  output logic signed [31:0]   out_score
);

  logic               s2_valid;
  nbbc_pkg::rec_t     s2;
  logic               out_free;
  logic               s2_go;
  logic signed [31:0] score;
  logic signed [31:0] thr;

  assign out_free = !out_valid || m_tready;
  assign s2_go    = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_go;
  assign score    = nbbc_pkg::sat_add({{16{prior[15]}}, prior}, s2.sum);
  assign thr      = decision[15] ? '0 : {16'd0, decision};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rec_valid) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid) begin
      s2 <= rec;
    end
    if (s2_go) begin
      out_verdict <= (score > thr);
      out_label   <= s2.label;
      out_score   <= score;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the naive Bayes binary classifier: a scoreboard class predicts
// verdict, outcome and score per record; plain tasks drive the stream and APB ports.
// Depends on nbbc_pkg and naive_bayes_binary_classifier.
module tb_top;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int SAT_BEATS    = 8;
  localparam int PHASE_ITEMS  = 280;

  localparam logic signed [15:0] PRIOR_SET [6] = '{-16'sd32768, 16'sd32767, 16'sd0,
                                                    16'sd0, -16'sd1, 16'sd12000};
  localparam logic signed [15:0] DECISION_SET [6] = '{16'sd32767, -16'sd32768, 16'sd0,
                                                       16'sd0, 16'sd1,
                                                       nbbc_pkg::DECISION_RESET};

  typedef struct {
    logic              verdict;
    logic [1:0]        outcome;
    logic signed [31:0] score;
  } verdict_t;

  class verdict_board;
    logic signed [15:0] weights [1024];
    logic signed [31:0] sum_acc;
    logic signed [15:0] prior;
    logic signed [15:0] decision;
    verdict_t           verdicts_due [$];
    int unsigned        mismatches;

    function new();
      foreach (weights[i]) weights[i] = '0;
      sum_acc    = '0;
      prior      = nbbc_pkg::PRIOR_RESET;
      decision   = nbbc_pkg::DECISION_RESET;
      mismatches = 0;
    endfunction

    function logic signed [31:0] clamp_add(logic signed [31:0] a, logic signed [31:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(nbbc_pkg::SUM_MAX)) return nbbc_pkg::SUM_MAX;
      if (s < longint'(nbbc_pkg::SUM_MIN)) return nbbc_pkg::SUM_MIN;
      return s[31:0];
    endfunction

    function void set_reg(logic idx, logic signed [15:0] val);
      if (idx == nbbc_pkg::REG_PRIOR) prior = val;
      else decision = val;
    endfunction

    function void log_beat(logic op, logic [9:0] idx, logic signed [15:0] wv, logic pres,
                           logic lab, logic last);
      verdict_t v;
      logic signed [31:0] thr;
      if (op == nbbc_pkg::OP_WRITE) begin
        weights[idx] = wv;
        return;
      end
      if (pres) sum_acc = clamp_add(sum_acc, weights[idx]);
      if (!last) return;
      v.score   = clamp_add(prior, sum_acc);
      thr       = decision;
      if (thr < 0) thr = 0;
      v.verdict = v.score > thr;
      v.outcome = {lab, v.verdict};
      verdicts_due.push_back(v);
      sum_acc = '0;
    endfunction

    function void flag(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void match_verdict(logic [39:0] beat);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        flag("unexpected result beat", 0, longint'(beat));
        return;
      end
      want = verdicts_due.pop_front();
      if (beat[0] !== want.verdict) flag("verdict", want.verdict, beat[0]);
      if (beat[2:1] !== want.outcome) flag("outcome", want.outcome, beat[2:1]);
      if (beat[34:3] !== want.score) flag("score", want.score, $signed(beat[34:3]));
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // feature_index[9:0], weight_value[25:10], present[26],
                               // true_label[27], zero[31:28]
  logic        s_tuser  = 1'b0;  // opcode[0]
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;  // verdict[0], outcome[2:1], score[34:3], zero[39:35]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  verdict_board board = new();
  int          cycle_count = 0;
  int          holds_asked = 0;
  int          holds_given = 0;
  int          burst_left  = 0;
  int          seg_left    = 0;
  int          seg_mode    = 0;
  bit          steady      = 1'b0;

  naive_bayes_binary_classifier u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.match_verdict(m_tdata);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (holds_given != holds_asked) begin
        holds_given++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 160);
        end
        seg_left--;
        case (seg_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 9) < 7;
          2: m_tready <= $urandom_range(0, 9) < 2;
          default: m_tready <= (seg_left % 4) == 0;
        endcase
      end
    end
  end

  task automatic send_beat(input logic op, input logic [9:0] idx, input logic [15:0] wv,
                           input logic pres, input logic lab, input logic last);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, lab, pres, wv, idx};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.log_beat(op, idx, wv, pres, lab, last);
  endtask

  // bursts of random length, random gaps between them unless held steady
  task automatic pace();
    int n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    if (!steady) begin
      n = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic idx, input logic signed [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
  endtask

  task automatic set_config(input logic signed [15:0] pr, input logic signed [15:0] dc);
    drain();
    apb_access(nbbc_pkg::REG_PRIOR, pr);
    apb_access(nbbc_pkg::REG_DECISION, dc);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // bias towards the table ends so written weights are read back
  function automatic logic [9:0] pick_index();
    logic [9:0] i;
    i = 10'($urandom);
    if ($urandom_range(0, 9) < 6) i[8:4] = {5{i[9]}};
    return i;
  endfunction

  task automatic random_phase(input int items);
    int sent;
    int len;
    int k;
    int n;
    int pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_beat(nbbc_pkg::OP_WRITE, pick_index(), 16'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom));
          pace();
          sent++;
        end
      end else begin
        len = (pick < 25) ? 1 : $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_beat(nbbc_pkg::OP_WRITE, pick_index(), 16'($urandom), 1'($urandom),
                      1'($urandom), 1'b0);
            pace();
            sent++;
          end
          send_beat(nbbc_pkg::OP_FEATURE, pick_index(), 16'($urandom),
                    $urandom_range(0, 3) != 0, 1'($urandom), k == len - 1);
          pace();
          sent++;
        end
      end
    end
  endtask

  initial begin
    int p;
    logic signed [15:0] pr;
    logic signed [15:0] dc;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // cleared table, then extremes and alternating bit patterns
    send_beat(nbbc_pkg::OP_FEATURE, 10'd0, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_beat(nbbc_pkg::OP_WRITE, 10'd0, 16'h7FFF, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_WRITE, 10'd1023, 16'h8000, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_WRITE, 10'd341, 16'h5555, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_WRITE, 10'd682, 16'hAAAA, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd1023, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd682, 16'h0000, 1'b0, 1'b1, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd0, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd1023, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd341, 16'h0000, 1'b1, 1'b1, 1'b1);
    // score landing exactly on the threshold, read straight after the write
    send_beat(nbbc_pkg::OP_WRITE, 10'd7, 16'sd10204, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd7, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_beat(nbbc_pkg::OP_WRITE, 10'd8, 16'h0001, 1'b1, 1'b1, 1'b1);
    // registers change while a record is open
    send_beat(nbbc_pkg::OP_FEATURE, 10'd8, 16'h0000, 1'b1, 1'b0, 1'b0);
    set_config(16'sd100, -16'sd5);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd8, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_beat(nbbc_pkg::OP_WRITE, 10'd9, -16'sd100, 1'b0, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd9, 16'h0000, 1'b1, 1'b0, 1'b1);

    // long records at both extreme weights, prior pushed to both rails
    set_config(16'sd32767, nbbc_pkg::DECISION_RESET);
    repeat (SAT_BEATS) send_beat(nbbc_pkg::OP_FEATURE, 10'd0, 16'h0000, 1'b1, 1'b1, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd1023, 16'h0000, 1'b0, 1'b1, 1'b1);
    repeat (SAT_BEATS) send_beat(nbbc_pkg::OP_FEATURE, 10'd1023, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd0, 16'h0000, 1'b1, 1'b0, 1'b1);
    set_config(-16'sd32768, 16'sd0);
    repeat (SAT_BEATS) send_beat(nbbc_pkg::OP_FEATURE, 10'd1023, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_beat(nbbc_pkg::OP_FEATURE, 10'd0, 16'h0000, 1'b1, 1'b1, 1'b1);

    for (p = 0; p < 6; p++) begin
      pr = PRIOR_SET[p];
      dc = DECISION_SET[p];
      if (p == 3) begin
        pr = 16'($urandom);
        dc = 16'($urandom);
      end
      set_config(pr, dc);
      steady = (p % 3) == 1;
      if (p == 2) begin
        // hold the result side off while items keep coming
        holds_asked++;
        steady = 1'b1;
        random_phase(120);
        steady = 1'b0;
        random_phase(PHASE_ITEMS - 120);
      end else if (p == 4) begin
        random_phase(PHASE_ITEMS / 2);
        drain();
        random_phase(PHASE_ITEMS / 2);
      end else begin
        random_phase(PHASE_ITEMS);
      end
    end

    drain();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
